// ----- design/imhq_pkg.sv -----
package imhq_pkg;

  localparam int KEY_SPACE  = 256;
  localparam int KEY_W      = $clog2(KEY_SPACE);
  localparam int POS_W      = $clog2(KEY_SPACE + 1);
  localparam int HEAP_DEPTH = KEY_SPACE + 1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELMIN = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_PEEK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_P,
    S_RM_K,
    S_RM_L,
    S_RM_M,
    S_UP,
    S_UP_C,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_C,
    S_PLACE,
    S_FIN,
    S_RES
  } st_t;

  // heap store port: key at a heap position
  typedef struct packed {
    logic we;
    pos_t waddr;
    key_t wdata;
    pos_t raddr;
  } heap_req_t;

  // position map port: heap position of a key
  typedef struct packed {
    logic we;
    key_t waddr;
    pos_t wdata;
    key_t raddr;
  } pmap_req_t;

endpackage

// ----- design/imhq_ram.sv -----
module imhq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/imhq_seq.sv -----
module imhq_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  imhq_pkg::cmd_t      in_command,
  input  imhq_pkg::key_t      in_key,
  output imhq_pkg::heap_req_t heap_req,
  input  imhq_pkg::key_t      heap_rdata,
  output imhq_pkg::pmap_req_t pmap_req,
  input  imhq_pkg::pos_t      pmap_rdata,
  output logic                out_strobe,
  output imhq_pkg::status_t   out_status,
  output imhq_pkg::key_t      out_removed_key,
  output imhq_pkg::key_t      out_min_key,
  output logic                out_min_valid,
  output imhq_pkg::pos_t      out_count
);

  import imhq_pkg::*;

  st_t                  state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  status_t              status_r, status_nxt;
  key_t                 removed_r, removed_nxt;
  pos_t                 cnt_r, cnt_nxt;
  pos_t                 p_r, p_nxt;
  pos_t                 c_r, c_nxt;
  key_t                 mv_r, mv_nxt;
  key_t                 ck_r, ck_nxt;
  logic                 moved_r, moved_nxt;
  logic [KEY_SPACE-1:0] pvld_r, pvld_nxt;

  logic                 out_strobe_r, out_strobe_nxt;
  status_t              out_status_r, out_status_nxt;
  key_t                 out_removed_r, out_removed_nxt;
  key_t                 out_min_r, out_min_nxt;
  logic                 out_min_vld_r, out_min_vld_nxt;
  pos_t                 out_count_r, out_count_nxt;

  // the one shared comparator
  key_t                 cmp_a, cmp_b;
  logic                 cmp_lt;

  logic [POS_W:0]       l_pos, r_pos, cnt_ext;
  logic                 up_only;

  assign cmp_lt  = cmp_a < cmp_b;
  assign l_pos   = {p_r, 1'b0};
  assign r_pos   = l_pos + 1'b1;
  assign cnt_ext = {1'b0, cnt_r};
  // after a move upward, or for an insert, the heap below is already in order
  assign up_only = moved_r || (cmd_r == CMD_INSERT);

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      pvld_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pvld_r       <= pvld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    p_r           <= p_nxt;
    c_r           <= c_nxt;
    mv_r          <= mv_nxt;
    ck_r          <= ck_nxt;
    moved_r       <= moved_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_min_r     <= out_min_nxt;
    out_min_vld_r <= out_min_vld_nxt;
    out_count_r   <= out_count_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    status_nxt      = status_r;
    removed_nxt     = removed_r;
    cnt_nxt         = cnt_r;
    p_nxt           = p_r;
    c_nxt           = c_r;
    mv_nxt          = mv_r;
    ck_nxt          = ck_r;
    moved_nxt       = moved_r;
    pvld_nxt        = pvld_r;
    out_strobe_nxt  = 1'b0;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_min_nxt     = out_min_r;
    out_min_vld_nxt = out_min_vld_r;
    out_count_nxt   = out_count_r;
    heap_req        = '0;
    pmap_req        = '0;
    cmp_a           = mv_r;
    cmp_b           = heap_rdata;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_command;
          status_nxt  = ST_OK;
          removed_nxt = '0;
          moved_nxt   = 1'b0;
          case (in_command)
            CMD_INSERT: begin
              if (pvld_r[in_key]) begin
                status_nxt = ST_PRESENT;
                state_nxt  = S_FIN;
              end else if (cnt_r < POS_W'(KEY_SPACE)) begin
                cnt_nxt          = cnt_r + 1'b1;
                p_nxt            = cnt_r + 1'b1;
                mv_nxt           = in_key;
                pvld_nxt[in_key] = 1'b1;
                state_nxt        = S_UP;
              end else begin
                state_nxt = S_FIN;
              end
            end
            CMD_DELMIN: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                p_nxt     = POS_W'(1);
                state_nxt = S_RM_K;
              end
            end
            CMD_ERASE: begin
              if (!pvld_r[in_key]) begin
                status_nxt = ST_ABSENT;
                state_nxt  = S_FIN;
              end else begin
                pmap_req.raddr = in_key;
                state_nxt      = S_RM_P;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_RM_P: begin
        p_nxt     = pmap_rdata;
        state_nxt = S_RM_K;
      end
      S_RM_K: begin
        heap_req.raddr = p_r;
        state_nxt      = S_RM_L;
      end
      S_RM_L: begin
        // heap_rdata is the key leaving; fetch the last entry to fill the hole
        removed_nxt          = heap_rdata;
        pvld_nxt[heap_rdata] = 1'b0;
        heap_req.raddr       = cnt_r;
        cnt_nxt              = cnt_r - 1'b1;
        state_nxt            = (p_r == cnt_r) ? S_FIN : S_RM_M;
      end
      S_RM_M: begin
        mv_nxt    = heap_rdata;
        state_nxt = S_UP;
      end
      S_UP: begin
        if (p_r > POS_W'(1)) begin
          heap_req.raddr = p_r >> 1;
          state_nxt      = S_UP_C;
        end else begin
          state_nxt = up_only ? S_PLACE : S_DN;
        end
      end
      S_UP_C: begin
        cmp_a = mv_r;
        cmp_b = heap_rdata;
        if (cmp_lt) begin
          heap_req.we    = 1'b1;
          heap_req.waddr = p_r;
          heap_req.wdata = heap_rdata;
          pmap_req.we    = 1'b1;
          pmap_req.waddr = heap_rdata;
          pmap_req.wdata = p_r;
          p_nxt          = p_r >> 1;
          moved_nxt      = 1'b1;
          state_nxt      = S_UP;
        end else begin
          state_nxt = up_only ? S_PLACE : S_DN;
        end
      end
      S_DN: begin
        if (l_pos <= cnt_ext) begin
          heap_req.raddr = l_pos[POS_W-1:0];
          c_nxt          = l_pos[POS_W-1:0];
          state_nxt      = S_DN_L;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DN_L: begin
        ck_nxt = heap_rdata;
        if (r_pos <= cnt_ext) begin
          heap_req.raddr = r_pos[POS_W-1:0];
          state_nxt      = S_DN_R;
        end else begin
          state_nxt = S_DN_C;
        end
      end
      S_DN_R: begin
        cmp_a = heap_rdata;
        cmp_b = ck_r;
        if (cmp_lt) begin
          ck_nxt = heap_rdata;
          c_nxt  = c_r + 1'b1;
        end
        state_nxt = S_DN_C;
      end
      S_DN_C: begin
        cmp_a = ck_r;
        cmp_b = mv_r;
        if (cmp_lt) begin
          heap_req.we    = 1'b1;
          heap_req.waddr = p_r;
          heap_req.wdata = ck_r;
          pmap_req.we    = 1'b1;
          pmap_req.waddr = ck_r;
          pmap_req.wdata = p_r;
          p_nxt          = c_r;
          state_nxt      = S_DN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        heap_req.we    = 1'b1;
        heap_req.waddr = p_r;
        heap_req.wdata = mv_r;
        pmap_req.we    = 1'b1;
        pmap_req.waddr = mv_r;
        pmap_req.wdata = p_r;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        heap_req.raddr = POS_W'(1);
        state_nxt      = S_RES;
      end
      S_RES: begin
        out_strobe_nxt  = 1'b1;
        out_status_nxt  = status_r;
        out_removed_nxt = removed_r;
        out_min_nxt     = (cnt_r != '0) ? heap_rdata : '0;
        out_min_vld_nxt = (cnt_r != '0);
        out_count_nxt   = cnt_r;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_removed_key = out_removed_r;
  assign out_min_key     = out_min_r;
  assign out_min_valid   = out_min_vld_r;
  assign out_count       = out_count_r;

  // key count and the presence bits must agree at all times
  a_cnt_matches_vld: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pvld_r) == int'(cnt_r))
    else $error("entry count differs from number of present keys");

  // every heap move updates the position map for the same key and slot
  a_map_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    heap_req.we |-> (pmap_req.we && pmap_req.waddr == heap_req.wdata &&
                     pmap_req.wdata == heap_req.waddr))
    else $error("heap write without matching position map write");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= POS_W'(KEY_SPACE))
    else $error("entry count above key space");

  a_strobe_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == S_RES && state_r == S_IDLE))
    else $error("result strobe outside result step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

// ----- design/indexed_min_heap_queue_unit.sv -----
// Channel  Fields                                                          Handshake
// input    in_command in_key                                               start & !busy
// result   out_status out_removed_key out_min_key out_min_valid out_count  out_strobe
//
// Peek and the error paths read the root and then raise the result strobe; insert
// sifts the new entry up, a parent read and a compare per level, then places it;
// delete and erase read the key leaving and the last entry, sift that entry up or
// down and place it, unless the last entry itself leaves. Worst case: erase of the
// root of a full heap. At most one heap read per cycle feeds the shared comparator.
// Reset (rst_n low, synchronous) empties the heap; no clearing pass is needed.
// busy is high from the accepted command until the result strobe; the strobe
// cycle already accepts the next command. The receiver cannot stall.
module indexed_min_heap_queue_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  imhq_pkg::cmd_t    in_command,
  input  imhq_pkg::key_t    in_key,
  output logic              out_strobe,
  output imhq_pkg::status_t out_status,
  output imhq_pkg::key_t    out_removed_key,
  output imhq_pkg::key_t    out_min_key,
  output logic              out_min_valid,
  output imhq_pkg::pos_t    out_count
);

  import imhq_pkg::*;

  heap_req_t heap_req;
  pmap_req_t pmap_req;
  key_t      heap_rdata;
  pos_t      pmap_rdata;

  imhq_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_key          (in_key),
    .heap_req        (heap_req),
    .heap_rdata      (heap_rdata),
    .pmap_req        (pmap_req),
    .pmap_rdata      (pmap_rdata),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_removed_key (out_removed_key),
    .out_min_key     (out_min_key),
    .out_min_valid   (out_min_valid),
    .out_count       (out_count)
  );

  // heap positions 1..count; position 0 unused
  imhq_ram #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (KEY_W)
  ) u_heap (
    .clk   (clk),
    .we    (heap_req.we),
    .waddr (heap_req.waddr),
    .wdata (heap_req.wdata),
    .raddr (heap_req.raddr),
    .rdata (heap_rdata)
  );

  // entries of absent keys are masked by presence bits in the sequencer
  imhq_ram #(
    .DEPTH (KEY_SPACE),
    .WIDTH (POS_W)
  ) u_pmap (
    .clk   (clk),
    .we    (pmap_req.we),
    .waddr (pmap_req.waddr),
    .wdata (pmap_req.wdata),
    .raddr (pmap_req.raddr),
    .rdata (pmap_rdata)
  );

endmodule

// ----- test/tb_indexed_min_heap_queue_unit.sv -----
module tb_indexed_min_heap_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import imhq_pkg::*;

  typedef struct {
    status_t status;
    key_t    removed_key;
    key_t    min_key;
    logic    min_valid;
    pos_t    count;
  } heap_result_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    in_command = CMD_PEEK;
  key_t    in_key = '0;
  logic    out_strobe;
  status_t out_status;
  key_t    out_removed_key;
  key_t    out_min_key;
  logic    out_min_valid;
  pos_t    out_count;

  // shadow heap kept in step with every accepted command
  key_t heap_keys [0:HEAP_DEPTH-1];
  pos_t key_pos [0:KEY_SPACE-1];
  int   heap_count = 0;

  heap_result_t pending_results[$];
  int           mismatch_count = 0;
  bit           gaps_on = 1'b1;

  indexed_min_heap_queue_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_key         (in_key),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_removed_key(out_removed_key),
    .out_min_key    (out_min_key),
    .out_min_valid  (out_min_valid),
    .out_count      (out_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void heap_swap(int a, int b);
    key_t ka;
    key_t kb;
    ka = heap_keys[a];
    kb = heap_keys[b];
    heap_keys[a] = kb;
    heap_keys[b] = ka;
    key_pos[kb] = pos_t'(a);
    key_pos[ka] = pos_t'(b);
  endfunction

  function automatic void heap_sift_up(int p);
    while (p > 1 && heap_keys[p] < heap_keys[p/2]) begin
      heap_swap(p, p/2);
      p = p/2;
    end
  endfunction

  // take out the entry at position p: last entry fills the hole, then up and down
  function automatic key_t heap_remove_at(int p);
    key_t k;
    int   last;
    int   best;
    int   l;
    bit   done;
    k = heap_keys[p];
    last = heap_count;
    heap_swap(p, last);
    key_pos[k] = '0;
    heap_count = last - 1;
    if (p < last) begin
      heap_sift_up(p);
      done = 1'b0;
      while (!done) begin
        best = p;
        l = 2 * p;
        if (l <= heap_count && heap_keys[l] < heap_keys[best]) best = l;
        if (l + 1 <= heap_count && heap_keys[l+1] < heap_keys[best]) best = l + 1;
        if (best == p) begin
          done = 1'b1;
        end else begin
          heap_swap(p, best);
          p = best;
        end
      end
    end
    return k;
  endfunction

  function automatic heap_result_t heap_apply(cmd_t cmd, key_t key);
    heap_result_t r;
    int           kidx;
    r.status = ST_OK;
    r.removed_key = '0;
    kidx = int'(key);
    case (cmd)
      CMD_INSERT: begin
        if (kidx >= KEY_SPACE) begin
          r.status = ST_ABSENT;
        end else if (key_pos[key] != '0) begin
          r.status = ST_PRESENT;
        end else if (heap_count < KEY_SPACE) begin
          heap_count++;
          heap_keys[heap_count] = key;
          key_pos[key] = pos_t'(heap_count);
          heap_sift_up(heap_count);
        end
      end
      CMD_DELMIN: begin
        if (heap_count == 0) r.status = ST_EMPTY;
        else r.removed_key = heap_remove_at(1);
      end
      CMD_ERASE: begin
        if (kidx >= KEY_SPACE || key_pos[key] == '0 || int'(key_pos[key]) > heap_count)
          r.status = ST_ABSENT;
        else
          r.removed_key = heap_remove_at(int'(key_pos[key]));
      end
      CMD_PEEK: ;
    endcase
    r.min_key = (heap_count != 0) ? heap_keys[1] : '0;
    r.min_valid = (heap_count != 0);
    r.count = pos_t'(heap_count);
    return r;
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ERROR %s", $time, msg);
  endtask

  // one command transaction; optional idle burst first, junk on the bus while idle
  task automatic issue_command(cmd_t cmd, key_t key);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      in_key <= key_t'($urandom);
      in_command <= cmd_t'($urandom_range(0, 3));
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.insert(pending_results.size(), heap_apply(cmd, key));
  endtask

  function automatic key_t pick_key();
    if ($urandom_range(0, 1) == 0) return key_t'($urandom_range(0, 15));
    return key_t'($urandom);
  endfunction

  function automatic key_t pick_present_key();
    if (heap_count == 0) return key_t'($urandom);
    return heap_keys[$urandom_range(1, heap_count)];
  endfunction

  task automatic test_empty_heap();
    issue_command(CMD_DELMIN, 8'hff);
    issue_command(CMD_ERASE, 8'h00);
    issue_command(CMD_ERASE, 8'hff);
    issue_command(CMD_PEEK, 8'h5a);
  endtask

  task automatic test_directed_cases();
    issue_command(CMD_INSERT, 8'hff);
    issue_command(CMD_INSERT, 8'h00);
    issue_command(CMD_INSERT, 8'hff);   // already present
    issue_command(CMD_PEEK, 8'h00);
    issue_command(CMD_ERASE, 8'h80);    // absent
    issue_command(CMD_INSERT, 8'h80);
    issue_command(CMD_INSERT, 8'h7f);
    issue_command(CMD_INSERT, 8'h01);
    issue_command(CMD_ERASE, 8'h80);    // neither root nor last slot
    issue_command(CMD_ERASE, 8'h01);
    issue_command(CMD_DELMIN, 8'h00);
    issue_command(CMD_DELMIN, 8'hff);
    issue_command(CMD_ERASE, 8'hff);    // last entry
    issue_command(CMD_DELMIN, 8'h00);   // empty again
    issue_command(CMD_INSERT, 8'haa);
    issue_command(CMD_INSERT, 8'h55);
    issue_command(CMD_ERASE, 8'h55);    // root
    issue_command(CMD_ERASE, 8'haa);
    issue_command(CMD_PEEK, 8'hff);
  endtask

  task automatic test_random_mix(int n);
    int   sel;
    key_t key;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        issue_command(CMD_INSERT, pick_key());
      end else if (sel < 60) begin
        issue_command(CMD_DELMIN, key_t'($urandom));
      end else if (sel < 90) begin
        key = ($urandom_range(0, 9) < 7) ? pick_present_key() : pick_key();
        issue_command(CMD_ERASE, key);
      end else begin
        issue_command(CMD_PEEK, key_t'($urandom));
      end
    end
  endtask

  // every key in random order up to a full heap, then erase half, then drain
  task automatic test_fill_and_drain();
    key_t order [0:KEY_SPACE-1];
    key_t tmp;
    int   j;
    while (heap_count != 0) issue_command(CMD_DELMIN, key_t'($urandom));
    for (int i = 0; i < KEY_SPACE; i++) order[i] = key_t'(i);
    for (int i = KEY_SPACE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < KEY_SPACE; i++) issue_command(CMD_INSERT, order[i]);
    issue_command(CMD_INSERT, key_t'($urandom));   // full, always present
    issue_command(CMD_PEEK, key_t'($urandom));
    for (int i = 0; i < KEY_SPACE / 2; i++) issue_command(CMD_ERASE, pick_present_key());
    while (heap_count != 0) issue_command(CMD_DELMIN, key_t'($urandom));
    issue_command(CMD_DELMIN, key_t'($urandom));
  endtask

  always @(posedge clk) begin : result_check
    heap_result_t exp_r;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_failure("result with no pending command");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status || out_removed_key !== exp_r.removed_key ||
            out_min_key !== exp_r.min_key || out_min_valid !== exp_r.min_valid ||
            out_count !== exp_r.count)
          note_failure($sformatf(
            "exp st=%0d rm=%0d min=%0d mv=%0b cnt=%0d got st=%0d rm=%0d min=%0d mv=%0b cnt=%0d",
            exp_r.status, exp_r.removed_key, exp_r.min_key, exp_r.min_valid, exp_r.count,
            out_status, out_removed_key, out_min_key, out_min_valid, out_count));
      end
    end
  end

  initial begin
    foreach (key_pos[i]) key_pos[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_heap();
    test_directed_cases();
    test_random_mix(300);
    test_fill_and_drain();
    gaps_on = 1'b0;
    test_random_mix(130);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_indexed_min_heap_queue_unit: PASS");
    end else begin
      $display("tb_indexed_min_heap_queue_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_indexed_min_heap_queue_unit: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/imhq_pkg.sv
design/imhq_ram.sv
design/imhq_seq.sv
design/indexed_min_heap_queue_unit.sv
test/tb_indexed_min_heap_queue_unit.sv
